@@ src/rsfc_pkg.sv @@
// Shared types and constants for the rolling/spin friction cone projection.
// Used by rsfc_cone, the top level and the bench; depends on nothing.
package rsfc_pkg;

  // Friction coefficients are unsigned Q8.24.
  localparam int KW         = 32;
  localparam int COEFF_FRAC = 24;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROLLING  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPINNING = 1'b1;

  // Outcome of one cone test.
  typedef enum logic [1:0] {
    ST_KEEP,
    ST_ZERO,
    ST_PROJ
  } cone_st_t;

endpackage

@@ src/rsfc_delay.sv @@
// Enabled shift line that keeps side data aligned with the arithmetic pipelines.
// Depends on nothing.
module rsfc_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

@@ src/rsfc_mul.sv @@
// Two-stage unsigned multiplier built from 32x32 partial products.
// Depends on nothing; the partial products and the sum are each registered.
module rsfc_mul #(
  parameter int AW = 48,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NA = (AW + 31) / 32;
  localparam int NB = (BW + 31) / 32;
  localparam int PW = AW + BW;
  localparam int SW = (NA + NB) * 32;

  logic [NA*32-1:0] ae;
  logic [NB*32-1:0] be;
  logic [63:0]      pp [NA][NB];
  logic [SW-1:0]    acc;

  assign ae = (NA*32)'(a);
  assign be = (NB*32)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= ae[i*32 +: 32] * be[j*32 +: 32];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc[PW-1:0];
    end
  end

endmodule

@@ src/rsfc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing. The caller guarantees n < d * 2^QW.
module rsfc_div #(
  parameter int NW = 96,
  parameter int DW = 48,
  parameter int QW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q
);

  localparam int RW = DW + 1;

  logic [RW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] d_r   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [RW-1:0] rem_i;
    logic [RW-1:0] trial;
    logic [QW-1:0] low_i;
    logic [QW-1:0] q_i;
    logic [DW-1:0] d_i;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_i = RW'(n >> QW);
      assign low_i = n[QW-1:0];
      assign q_i   = '0;
      assign d_i   = d;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign low_i = low_r[s-1];
      assign q_i   = q_r[s-1];
      assign d_i   = d_r[s-1];
    end

    // The running remainder stays below the divisor, so its top bit is free.
    assign trial = {rem_i[DW-1:0], low_i[QW-1]};
    assign ge    = trial >= RW'(d_i);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? trial - RW'(d_i) : trial;
        low_r[s] <= low_i << 1;
        q_r[s]   <= {q_i[QW-2:0], ge};
        d_r[s]   <= d_i;
      end
    end
  end

  assign q = q_r[QW-1];

endmodule

@@ src/rsfc_isqrt.sv @@
// Pipelined integer square root of a + b, one root bit per stage.
// Depends on nothing; the sum is registered ahead of the root stages.
module rsfc_isqrt #(
  parameter int OW = 48
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*OW-1:0] a,
  input  logic [2*OW-1:0] b,
  output logic [OW-1:0]   r
);

  localparam int IW = 2 * OW;
  localparam int RW = OW + 2;

  logic [IW-1:0] s_r;
  logic [RW-1:0] rem_r  [OW];
  logic [OW-1:0] root_r [OW];
  logic [IW-1:0] x_r    [OW];

  // Both squares are at most 2^(2*OW-2), so the sum fits.
  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= a + b;
    end
  end

  for (genvar s = 0; s < OW; s++) begin : g_step
    logic [RW-1:0] rem_i;
    logic [OW-1:0] root_i;
    logic [IW-1:0] x_i;
    logic [RW-1:0] t;
    logic [RW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = s_r;
    end else begin : g_next
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
      assign x_i    = x_r[s-1];
    end

    assign t     = {rem_i[RW-3:0], x_i[IW-1 -: 2]};
    assign trial = {root_i, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? t - trial : t;
        root_r[s] <= {root_i[OW-2:0], ge};
        x_r[s]    <= x_i << 2;
      end
    end
  end

  assign r = root_r[OW-1];

endmodule

@@ src/rsfc_cone.sv @@
// One cone test and projection: classifies (f, t) and computes P and R = P*k.
// Depends on rsfc_pkg, rsfc_mul, rsfc_div and rsfc_delay.
module rsfc_cone #(
  parameter int W = 48
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [rsfc_pkg::KW-1:0]  k,
  input  logic signed [W-1:0]      f,
  input  logic [W-1:0]             t,
  output rsfc_pkg::cone_st_t       st,
  output logic [W-1:0]             p,
  output logic [W-1:0]             r
);

  import rsfc_pkg::*;

  localparam int MW = W + KW;
  localparam int NW = W + KW + COEFF_FRAC + 1;
  localparam int DW = 2 * KW + 1;

  logic          fneg, fzero;
  logic [W-1:0]  fmag;
  logic [MW-1:0] rhs, tk;
  logic          fneg2, fzero2;
  logic [W-1:0]  fmag2, t2;
  logic          upper, polar;
  cone_st_t      st_next, st3, st4;
  logic [MW-1:0] tk3;
  logic          fneg3;
  logic [W-1:0]  fmag3;
  logic [NW-1:0] num_next, num4, lhs, fw;
  logic [2*KW-1:0] kk;
  logic [DW-1:0] den;
  logic [W-1:0]  p_q;
  logic [1:0]    st5;
  logic [1:0]    st_o;
  logic [MW-1:0] pk;

  assign fneg  = f[W-1];
  assign fmag  = fneg ? W'(-f) : W'(f);
  assign fzero = (f == '0);

  rsfc_mul #(.AW(W), .BW(KW)) u_rhs (.clk(clk), .en(en), .a(fmag), .b(k), .p(rhs));
  rsfc_mul #(.AW(W), .BW(KW)) u_tk  (.clk(clk), .en(en), .a(t), .b(k), .p(tk));

  rsfc_delay #(.WIDTH(2*W+2), .DEPTH(2)) u_dly_in (
    .clk(clk), .en(en),
    .d({fneg, fzero, fmag, t}),
    .q({fneg2, fzero2, fmag2, t2})
  );

  // Upper cone: t*2^24 < k*f. Polar cone: f is zero or t*k < -f*2^24.
  assign upper   = !fneg2 && ((MW'(t2) << COEFF_FRAC) < rhs);
  assign polar   = fzero2 || (fneg2 && (tk < (MW'(fmag2) << COEFF_FRAC)));
  assign st_next = upper ? ST_KEEP : (polar ? ST_ZERO : ST_PROJ);

  always_ff @(posedge clk) begin
    if (en) begin
      st3   <= st_next;
      tk3   <= tk;
      fneg3 <= fneg2;
      fmag3 <= fmag2;
    end
  end

  // In the projection case the numerator t*k*2^24 + f*2^48 is never negative.
  assign lhs = NW'(tk3) << COEFF_FRAC;
  assign fw  = NW'(fmag3) << (2 * COEFF_FRAC);

  always_comb begin
    if (st3 != ST_PROJ) begin
      num_next = '0;
    end else if (fneg3) begin
      num_next = lhs - fw;
    end else begin
      num_next = lhs + fw;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num4 <= num_next;
      st4  <= st3;
    end
  end

  // The user changes the coefficient only while the block is idle (unenforced).
  always_ff @(posedge clk) begin
    kk  <= k * k;
    den <= DW'(kk) + (DW'(1) << (2 * COEFF_FRAC));
  end

  rsfc_div #(.NW(NW), .DW(DW), .QW(W)) u_div (
    .clk(clk), .en(en), .n(num4), .d(den), .q(p_q)
  );

  rsfc_delay #(.WIDTH(2), .DEPTH(W)) u_dly_st (
    .clk(clk), .en(en), .d(st4), .q(st5)
  );

  rsfc_mul #(.AW(W), .BW(KW)) u_pk (.clk(clk), .en(en), .a(p_q), .b(k), .p(pk));

  rsfc_delay #(.WIDTH(W+2), .DEPTH(2)) u_dly_out (
    .clk(clk), .en(en), .d({st5, p_q}), .q({st_o, p})
  );

  assign st = cone_st_t'(st_o);
  // R never exceeds the tangential size, so W bits hold it.
  assign r  = pk[W+COEFF_FRAC-1:COEFF_FRAC];

endmodule

@@ src/rsfc_scale.sv @@
// Scales one tangential component: q = r * c / t, truncated.
// Depends on rsfc_mul, rsfc_div and rsfc_delay.
module rsfc_scale #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] r,
  input  logic [W-1:0] c,
  input  logic [W-1:0] t,
  output logic [W-1:0] q
);

  logic [2*W-1:0] rc;
  logic [W-1:0]   t2;

  rsfc_mul #(.AW(W), .BW(W)) u_mul (.clk(clk), .en(en), .a(r), .b(c), .p(rc));

  rsfc_delay #(.WIDTH(W), .DEPTH(2)) u_dly_t (.clk(clk), .en(en), .d(t), .q(t2));

  rsfc_div #(.NW(2*W), .DW(W), .QW(W)) u_div (
    .clk(clk), .en(en), .n(rc), .d(t2), .q(q)
  );

endmodule

@@ src/rolling_spin_friction_cone_project_core.sv @@
// Top level of the rolling/spin friction cone projection.
// Depends on rsfc_pkg, rsfc_mul, rsfc_isqrt, rsfc_cone, rsfc_scale and rsfc_delay.
//
// Usage:
//   One contact (normal force, spin torque, two rolling torques, signed
//   fixed point) is taken per transfer on the input channel, and one
//   projected result per item leaves on the output channel, in order.
//   The user sets the two coefficients through the write port while no item
//   is in flight; the block does not enforce this. Index 0 is the rolling
//   coefficient, index 1 the spinning one. The rolling-norm square root,
//   the cone divider and the component divider each retire one bit per
//   stage. Throughput is one item per cycle unless the receiver stalls.
//   Both cones run side by side on the original normal force.
//   Reset clears both coefficients and empties the pipeline. When the
//   receiver stalls with a result waiting, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated.
module rolling_spin_friction_cone_project_core #(
  parameter int VALUE_WIDTH = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [VALUE_WIDTH-1:0]       normal_force,
  input  logic signed [VALUE_WIDTH-1:0]       spin_torque,
  input  logic signed [VALUE_WIDTH-1:0]       roll_u,
  input  logic signed [VALUE_WIDTH-1:0]       roll_v,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [VALUE_WIDTH-1:0]       normal_out,
  output logic signed [VALUE_WIDTH-1:0]       spin_out,
  output logic signed [VALUE_WIDTH-1:0]       roll_u_out,
  output logic signed [VALUE_WIDTH-1:0]       roll_v_out,
  input  logic                                cfg_en,
  input  logic [rsfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rsfc_pkg::KW-1:0]             cfg_data
);

  import rsfc_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int LS  = W + 3;
  localparam int LC  = W + 6;
  localparam int LQ  = W + 2;
  localparam int LAT = LS + LC + LQ + 1;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

  logic [KW-1:0]    rolling_coeff, spinning_coeff;
  logic             adv;
  logic [LAT-1:0]   vld;
  logic [W-1:0]     umag, vmag;
  logic [2*W-1:0]   uu, vv;
  logic [W-1:0]     troll;
  logic signed [W-1:0] f1, s1, u1, v1;
  logic [W-1:0]     s1mag, u1mag, v1mag;
  cone_st_t         st_s, st_r;
  logic [W-1:0]     p_s, r_s, p_r, r_r;
  logic [W-1:0]     t2, um2, vm2, qu, qv;
  logic [1:0]       st_s3, st_r3;
  logic [W-1:0]     p_s3, r_s3, p_r3;
  logic signed [W-1:0] f3, s3, u3, v3;
  logic [W-1:0]     no, so, uo, vo;

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling_coeff  <= '0;
      spinning_coeff <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_ROLLING:  rolling_coeff  <= cfg_data;
        REG_SPINNING: spinning_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole whenever the output register can be refilled.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  // Rolling tangential size: floor(sqrt(u^2 + v^2)).
  assign umag = roll_u[W-1] ? W'(-roll_u) : W'(roll_u);
  assign vmag = roll_v[W-1] ? W'(-roll_v) : W'(roll_v);

  rsfc_mul #(.AW(W), .BW(W)) u_uu (.clk(clk), .en(adv), .a(umag), .b(umag), .p(uu));
  rsfc_mul #(.AW(W), .BW(W)) u_vv (.clk(clk), .en(adv), .a(vmag), .b(vmag), .p(vv));
  rsfc_isqrt #(.OW(W)) u_sqrt (.clk(clk), .en(adv), .a(uu), .b(vv), .r(troll));

  rsfc_delay #(.WIDTH(4*W), .DEPTH(LS)) u_dly_raw1 (
    .clk(clk), .en(adv),
    .d({normal_force, spin_torque, roll_u, roll_v}),
    .q({f1, s1, u1, v1})
  );

  assign s1mag = s1[W-1] ? W'(-s1) : W'(s1);
  assign u1mag = u1[W-1] ? W'(-u1) : W'(u1);
  assign v1mag = v1[W-1] ? W'(-v1) : W'(v1);

  rsfc_cone #(.W(W)) u_cone_spin (
    .clk(clk), .en(adv), .k(spinning_coeff), .f(f1), .t(s1mag),
    .st(st_s), .p(p_s), .r(r_s)
  );

  rsfc_cone #(.W(W)) u_cone_roll (
    .clk(clk), .en(adv), .k(rolling_coeff), .f(f1), .t(troll),
    .st(st_r), .p(p_r), .r(r_r)
  );

  rsfc_delay #(.WIDTH(3*W), .DEPTH(LC)) u_dly_tan (
    .clk(clk), .en(adv), .d({troll, u1mag, v1mag}), .q({t2, um2, vm2})
  );

  rsfc_scale #(.W(W)) u_scale_u (
    .clk(clk), .en(adv), .r(r_r), .c(um2), .t(t2), .q(qu)
  );

  rsfc_scale #(.W(W)) u_scale_v (
    .clk(clk), .en(adv), .r(r_r), .c(vm2), .t(t2), .q(qv)
  );

  rsfc_delay #(.WIDTH(3*W+4), .DEPTH(LQ)) u_dly_cone (
    .clk(clk), .en(adv),
    .d({st_s, p_s, r_s, st_r, p_r}),
    .q({st_s3, p_s3, r_s3, st_r3, p_r3})
  );

  rsfc_delay #(.WIDTH(4*W), .DEPTH(LC+LQ)) u_dly_raw3 (
    .clk(clk), .en(adv), .d({f1, s1, u1, v1}), .q({f3, s3, u3, v3})
  );

  // Spin projection first, then the rolling stage may override the normal.
  // A projected spin torque is R itself, since it is scaled by |s| / |s|.
  always_comb begin
    no = W'(f3);
    so = W'(s3);
    uo = W'(u3);
    vo = W'(v3);
    if (spinning_coeff != '0) begin
      case (cone_st_t'(st_s3))
        ST_ZERO: begin
          no = '0;
          so = '0;
        end
        ST_PROJ: begin
          no = p_s3[W-1] ? VMAX : p_s3;
          so = s3[W-1] ? -r_s3 : r_s3;
        end
        default: ;
      endcase
    end
    if (rolling_coeff == '0) begin
      uo = '0;
      vo = '0;
      if (f3[W-1]) begin
        no = '0;
      end
    end else begin
      case (cone_st_t'(st_r3))
        ST_ZERO: begin
          no = '0;
          uo = '0;
          vo = '0;
        end
        ST_PROJ: begin
          no = p_r3[W-1] ? VMAX : p_r3;
          uo = u3[W-1] ? -qu : qu;
          vo = v3[W-1] ? -qv : qv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal_out <= no;
      spin_out   <= so;
      roll_u_out <= uo;
      roll_v_out <= vo;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted item did not enter the pipeline");
`endif

endmodule

@@ dv/rolling_spin_friction_cone_project_core_tb.sv @@
// Self-checking bench for the rolling/spin friction cone projection core.
// Depends on rsfc_pkg and rolling_spin_friction_cone_project_core.
`timescale 1ns / 1ps

module rolling_spin_friction_cone_project_core_tb;
  import rsfc_pkg::*;

  localparam int VW = 48;
  localparam int LATENCY = 3 * VW + 12;
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  typedef logic signed [VW-1:0] val_t;
  typedef struct packed {
    val_t f;
    val_t s;
    val_t u;
    val_t v;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  val_t normal_force = '0, spin_torque = '0, roll_u = '0, roll_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  val_t normal_out, spin_out, roll_u_out, roll_v_out;
  logic cfg_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [KW-1:0] cfg_data = '0;

  logic [KW-1:0] kr_model, ks_model;
  contact_t pending_q[$];
  contact_t projected_q[$];
  int errors = 0;
  bit hold_sender = 1'b0;
  int burst_left = 0, gap_left = 0, stall_phase = 0;

  rolling_spin_friction_cone_project_core #(.VALUE_WIDTH(VW)) dut (.*);

  always #2 clk = ~clk;

  function automatic logic [VW-1:0] mag_of(val_t x);
    return x[VW-1] ? -x : x;
  endfunction

  function automatic val_t clamp(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? {80'd0, VMIN} : {80'd0, VMAX};
    if (m > lim) m = lim;
    return neg ? val_t'(-m[VW-1:0]) : val_t'(m[VW-1:0]);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [127:0] x);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  // Cone test for one stage; on a projection, p is the new normal and r the
  // tangential radius.
  function automatic cone_st_t cone_test(logic [KW-1:0] k, val_t f, logic [63:0] t,
                                         output logic [127:0] p,
                                         output logic [63:0] r);
    logic signed [127:0] fw, lhs, rhs, tk, num, den;
    logic [127:0] m, pcl;
    fw = f;
    lhs = $signed({64'd0, t}) <<< COEFF_FRAC;
    rhs = $signed({96'd0, k}) * fw;
    p = '0;
    r = '0;
    if (lhs < rhs) return ST_KEEP;
    if (f == 0) return ST_ZERO;
    tk = $signed({64'd0, t}) * $signed({96'd0, k});
    if (tk < ((-fw) <<< COEFF_FRAC)) return ST_ZERO;
    num = (tk <<< COEFF_FRAC) + (fw <<< (2 * COEFF_FRAC));
    den = $signed({96'd0, k}) * $signed({96'd0, k}) + (128'sd1 <<< (2 * COEFF_FRAC));
    p = num[127] ? 128'd0 : 128'(num) / 128'(den);
    pcl = p[127:64] != 0 ? {64'd0, {64{1'b1}}} : {64'd0, p[63:0]};
    m = (pcl * {96'd0, k}) >> COEFF_FRAC;
    r = m[127:64] != 0 ? {64{1'b1}} : m[63:0];
    return ST_PROJ;
  endfunction

  function automatic val_t scale_component(logic [63:0] r, val_t c, logic [63:0] t);
    logic [127:0] q;
    q = t != 0 ? ({64'd0, r} * {80'd0, mag_of(c)}) / {64'd0, t} : 128'd0;
    return clamp(c[VW-1], q);
  endfunction

  function automatic contact_t project_contact(contact_t c);
    contact_t o;
    cone_st_t st;
    logic [127:0] p;
    logic [63:0] r, t;
    o = c;
    if (ks_model != 0) begin
      t = {16'd0, mag_of(c.s)};
      st = cone_test(ks_model, c.f, t, p, r);
      if (st == ST_ZERO) begin
        o.f = '0;
        o.s = '0;
      end else if (st == ST_PROJ) begin
        o.f = clamp(1'b0, p);
        o.s = scale_component(r, c.s, t);
      end
    end
    if (kr_model == 0) begin
      o.u = '0;
      o.v = '0;
      if (c.f[VW-1]) o.f = '0;
    end else begin
      t = int_sqrt({80'd0, mag_of(c.u)} * {80'd0, mag_of(c.u)}
                   + {80'd0, mag_of(c.v)} * {80'd0, mag_of(c.v)});
      st = cone_test(kr_model, c.f, t, p, r);
      if (st == ST_ZERO) begin
        o.f = '0;
        o.u = '0;
        o.v = '0;
      end else if (st == ST_PROJ) begin
        o.f = clamp(1'b0, p);
        o.u = scale_component(r, c.u, t);
        o.v = scale_component(r, c.v, t);
      end
    end
    return o;
  endfunction

  task automatic write_coeff(logic [CFG_INDEX_W-1:0] idx, logic [KW-1:0] val);
    @(posedge clk);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    if (idx == REG_ROLLING) kr_model = val;
    else ks_model = val;
  endtask

  task automatic drain_pipe();
    while (pending_q.size() != 0 || in_valid || projected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic val_t rand_val(int mode);
    val_t x;
    x = val_t'({$urandom(), $urandom()});
    case (mode)
      0: x = $signed(x) >>> $urandom_range(VW - 1, 0);
      1: x = val_t'($urandom_range(16, 0)) << $urandom_range(30, 16);
      2: x = $urandom_range(1) ? VMAX : VMIN;
      default: ;
    endcase
    if (mode == 1 && $urandom_range(1)) x = -x;
    return x;
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    int mode;
    mode = $urandom_range(9) < 6 ? 1 : $urandom_range(3);
    c.f = rand_val(mode);
    c.s = rand_val($urandom_range(4) == 0 ? $urandom_range(3) : mode);
    c.u = rand_val(mode);
    c.v = rand_val($urandom_range(4) == 0 ? $urandom_range(3) : mode);
    if ($urandom_range(9) == 0) c.f = '0;
    return c;
  endfunction

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) projected_q.push_back(project_contact(
          '{normal_force, spin_torque, roll_u, roll_v}));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 && !hold_sender) begin
          contact_t c;
          c = pending_q.pop_front();
          {normal_force, spin_torque, roll_u, roll_v} <= c;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(30);
            gap_left <= $urandom_range(3) == 0 ? $urandom_range(6) : 0;
          end
        end else in_valid <= 1'b0;
      end
    end
  end

  // Monitor plus receiver stall pattern.
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase % 64) < 20 ? 1'b1 : ($urandom_range(3) != 0);
      if (out_valid && out_ready) begin
        if (projected_q.size() == 0) begin
          $display("%0t: unexpected result %h %h %h %h", $time,
                   normal_out, spin_out, roll_u_out, roll_v_out);
          errors++;
        end else begin
          contact_t e;
          e = projected_q.pop_front();
          if (normal_out !== e.f) begin
            $display("%0t: normal_out expected %h actual %h", $time, e.f, normal_out);
            errors++;
          end
          if (spin_out !== e.s) begin
            $display("%0t: spin_out expected %h actual %h", $time, e.s, spin_out);
            errors++;
          end
          if (roll_u_out !== e.u) begin
            $display("%0t: roll_u_out expected %h actual %h", $time, e.u, roll_u_out);
            errors++;
          end
          if (roll_v_out !== e.v) begin
            $display("%0t: roll_v_out expected %h actual %h", $time, e.v, roll_v_out);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [KW-1:0] kr_set[5], ks_set[5];
    kr_set = '{32'd0, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_0001, 32'h0080_0000};
    ks_set = '{32'd0, 32'h0040_0000, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_0001};
    kr_model = '0;
    ks_model = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      write_coeff(REG_ROLLING, kr_set[ph]);
      write_coeff(REG_SPINNING, ks_set[ph]);
      if (ph == 0 || ph == 3) begin
        // Corners: extreme values, zero force, polar and upper cone cases.
        pending_q.push_back('{VMAX, VMAX, VMAX, VMAX});
        pending_q.push_back('{VMIN, VMIN, VMIN, VMIN});
        pending_q.push_back('{val_t'(0), VMAX, VMIN, val_t'(1)});
        pending_q.push_back('{val_t'(0), val_t'(0), val_t'(0), val_t'(0)});
        pending_q.push_back('{val_t'(48'h100_0000), val_t'(0), val_t'(0), val_t'(0)});
        pending_q.push_back('{val_t'(-48'sh100_0000), val_t'(1), val_t'(1), val_t'(0)});
        pending_q.push_back('{val_t'(48'h100_0000), val_t'(48'h500_0000),
                              val_t'(48'h300_0000), val_t'(-48'sh400_0000)});
        pending_q.push_back('{val_t'(-48'sh100_0000), val_t'(48'h500_0000),
                              val_t'(48'h300_0000), val_t'(48'h400_0000)});
        pending_q.push_back('{VMAX, val_t'(-48'sh100), val_t'(48'sh10), val_t'(-48'sh10)});
        pending_q.push_back('{val_t'(1), VMIN, VMAX, VMIN});
      end
      for (int i = 0; i < 90; i++) pending_q.push_back(rand_contact());
      if (ph == 2) begin
        while (pending_q.size() > 45) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || projected_q.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain_pipe();
    end
    if (errors == 0) $display("** rolling_spin_friction_cone_project_core: PASSED **");
    else $display("** rolling_spin_friction_cone_project_core: FAILED **");
    $finish;
  end

  initial begin
    #2ms;
    $display("** rolling_spin_friction_cone_project_core: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
src/rsfc_pkg.sv
src/rsfc_delay.sv
src/rsfc_mul.sv
src/rsfc_div.sv
src/rsfc_isqrt.sv
src/rsfc_cone.sv
src/rsfc_scale.sv
src/rolling_spin_friction_cone_project_core.sv
dv/rolling_spin_friction_cone_project_core_tb.sv
